>>> src/yay0_lz_decompressor_assert.svh
// assertion macros for the yay0 lz decompressor
// used by the controller; no other dependencies
`ifndef YAY0_LZ_DECOMPRESSOR_ASSERT_SVH
`define YAY0_LZ_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication
`define YLZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ylz assertion failed");

// next-cycle implication
`define YLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ylz assertion failed");

`endif

>>> src/ylz_pkg.sv
// shared types and constants for the yay0 lz decompressor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ylz_pkg;
	localparam logic [1:0] OP_FLAG  = 2'd0;
	localparam logic [1:0] OP_LINK  = 2'd1;
	localparam logic [1:0] OP_CHUNK = 2'd2;

	localparam int unsigned FLAG_BITS   = 32;
	localparam int unsigned OFFSET_W    = 12;
	localparam int unsigned COUNT_W     = 9;
	localparam logic [COUNT_W-1:0] SHORT_BIAS = 9'd2;
	localparam logic [COUNT_W-1:0] LONG_BIAS  = 9'h12;

	localparam logic [0:0] REG_OUTPUT_SIZE = 1'b0;

	typedef struct packed {
		logic accept;
		logic rd;
		logic wr;
		logic emit;
		logic last;
	} ylz_cmd_t;

	typedef struct packed {
		logic is_copy;
		logic cnt_one;
		logic lane_full;
		logic slot_free;
	} ylz_sts_t;
endpackage
`default_nettype wire

>>> src/ylz_ctrl.sv
// controller state machine for the yay0 lz decompressor
// depends on ylz_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "yay0_lz_decompressor_assert.svh"
module ylz_ctrl import ylz_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire ylz_sts_t sts,
	output ylz_cmd_t      cmd
);
	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WR, ST_EMIT} state_t;
	state_t state_q;
	logic   last_q;

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.accept = in_valid && in_ready;
		cmd.rd     = (state_q == ST_RD);
		cmd.wr     = (state_q == ST_WR);
		cmd.emit   = (state_q == ST_EMIT) && sts.slot_free;
		cmd.last   = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						if (sts.is_copy) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_EMIT;
							last_q  <= 1'b1;
						end
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (sts.cnt_one || sts.lane_full) begin
						state_q <= ST_EMIT;
						last_q  <= sts.cnt_one;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (sts.slot_free) begin
						state_q <= last_q ? ST_IDLE : ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`YLZ_ASSERT_NEXT(a_rd_then_wr, clk, arst_n, state_q == ST_RD, state_q == ST_WR)
	`YLZ_ASSERT_NEXT(a_emit_holds, clk, arst_n, state_q == ST_EMIT && !sts.slot_free, state_q == ST_EMIT)
	`YLZ_ASSERT_NEXT(a_last_idles, clk, arst_n, cmd.emit && last_q, state_q == ST_IDLE)
	`YLZ_ASSERT_NOW(a_emit_on_free, clk, arst_n, cmd.emit, sts.slot_free)
endmodule
`default_nettype wire

>>> src/ylz_datapath.sv
// datapath: decode state, history store, packing and result register
// depends on ylz_pkg
`timescale 1ns / 1ps
`default_nettype none
module ylz_datapath import ylz_pkg::*; #(
	parameter int unsigned WINDOW_SIZE = 4096,
	parameter int unsigned OUT_LANES   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_data,
	output logic [31:0]      cfg_size,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] data,
	input  wire ylz_cmd_t    cmd,
	output ylz_sts_t         sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_bytes,
	output logic [3:0]       byte_count,
	output logic             last_of_run,
	output logic [1:0]       next_need,
	output logic             done_res,
	output logic             error
);
	localparam int unsigned AW = $clog2(WINDOW_SIZE);
	localparam int unsigned LW = $clog2(OUT_LANES + 1);
	localparam int unsigned WW = 8 * OUT_LANES;

	logic [FLAG_BITS-1:0]   flag_q;
	logic [5:0]             left_q;
	logic [31:0]            produced_q;
	logic [OFFSET_W-1:0]    offset_q;
	logic [1:0]             expect_q;
	logic [31:0]            size_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic [8*OUT_LANES-1:0] word_q;
	logic [LW-1:0]          lane_q;
	logic                   err_q;
	logic [7:0]             hist_q [WINDOW_SIZE];
	logic [7:0]             rd_q;

	logic                   reject, lit, copy_req, copy_err, consume;
	logic [OFFSET_W-1:0]    cur_off;
	logic [COUNT_W-1:0]     cur_cnt;
	logic [FLAG_BITS-1:0]   shifted;
	logic [5:0]             left_dec;
	logic [1:0]             exp_after;
	logic                   hist_we;
	logic [AW-1:0]          wa, ra;
	logic [7:0]             wd;
	logic [31:0]            prod_inc;

	always_comb begin
		reject   = (produced_q >= size_q) || (op != expect_q);
		lit      = 1'b0;
		copy_req = 1'b0;
		consume  = 1'b0;
		cur_off  = offset_q;
		cur_cnt  = {1'b0, data[7:0]} + LONG_BIAS;
		if (expect_q == OP_LINK) begin
			cur_off = data[OFFSET_W-1:0];
			cur_cnt = COUNT_W'(data[15:12]) + SHORT_BIAS;
			if (data[15:12] != 4'd0) begin
				copy_req = 1'b1;
				consume  = 1'b1;
			end
		end else if (expect_q == OP_CHUNK) begin
			consume = 1'b1;
			if (flag_q[FLAG_BITS-1]) begin
				lit = 1'b1;
			end else begin
				copy_req = 1'b1;
			end
		end
		copy_err  = produced_q <= 32'(cur_off);
		shifted   = flag_q << 1;
		left_dec  = left_q - 6'd1;
		exp_after = (left_dec == 6'd0) ? OP_FLAG : (shifted[FLAG_BITS-1] ? OP_CHUNK : OP_LINK);
		prod_inc  = (produced_q == 32'hFFFF_FFFF) ? produced_q : produced_q + 32'd1;

		sts.is_copy   = !reject && copy_req && !copy_err;
		sts.cnt_one   = (cnt_q == COUNT_W'(1));
		sts.lane_full = (lane_q == LW'(OUT_LANES - 1));
		sts.slot_free = !out_valid || out_ready;

		hist_we = cmd.wr || (cmd.accept && !reject && lit);
		wa      = produced_q[AW-1:0];
		wd      = cmd.wr ? rd_q : data[7:0];
		ra      = produced_q[AW-1:0] - AW'(offset_q) - AW'(1);
		cfg_size = size_q;
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_q[wa] <= wd;
		end
		if (cmd.rd) begin
			rd_q <= hist_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q     <= '0;
			left_q     <= '0;
			produced_q <= '0;
			offset_q   <= '0;
			expect_q   <= OP_FLAG;
			size_q     <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.accept && !reject) begin
				if (expect_q == OP_FLAG) begin
					flag_q   <= data;
					left_q   <= 6'd32;
					expect_q <= data[FLAG_BITS-1] ? OP_CHUNK : OP_LINK;
				end else begin
					if (expect_q == OP_LINK) begin
						offset_q <= cur_off;
					end
					if (consume) begin
						flag_q   <= shifted;
						left_q   <= left_dec;
						expect_q <= exp_after;
					end else begin
						expect_q <= OP_CHUNK;
					end
				end
				if (lit) begin
					produced_q <= prod_inc;
				end
			end
			if (cmd.wr) begin
				produced_q <= prod_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cnt_q  <= cur_cnt;
			err_q  <= reject || (copy_req && copy_err);
			word_q <= (!reject && lit) ? WW'(data[7:0]) : '0;
			lane_q <= (!reject && lit) ? LW'(1) : '0;
		end
		if (cmd.wr) begin
			cnt_q  <= cnt_q - COUNT_W'(1);
			lane_q <= lane_q + LW'(1);
			for (int i = 0; i < OUT_LANES; i++) begin
				if (lane_q == LW'(i)) begin
					word_q[8*i +: 8] <= rd_q;
				end
			end
		end
		if (cmd.emit) begin
			out_bytes   <= 64'(word_q);
			byte_count  <= 4'(lane_q);
			last_of_run <= cmd.last;
			next_need   <= expect_q;
			done_res    <= produced_q >= size_q;
			error       <= err_q;
			word_q      <= '0;
			lane_q      <= '0;
		end
	end
endmodule
`default_nettype wire

>>> src/yay0_lz_decompressor.sv
// Yay0 LZ decompressor: takes flag words, link halfwords and chunk bytes in
// the order given by next_need and returns decoded bytes packed up to
// OUT_LANES per word. A flag word, a literal, a link whose count follows, or
// a rejected item has its one result word in the output register once the
// controller has passed from idle to its emit state and the output register
// is free. A copy reads each byte from the history and then writes it back,
// each byte depending on the one written before it, and emits a result word
// whenever OUT_LANES bytes are packed and at the end of the copy. A new item
// is taken only after the last word of the previous one is in the output
// register; a full output register stalls the word behind it.
// depends on ylz_pkg, ylz_ctrl and ylz_datapath
`timescale 1ns / 1ps
`default_nettype none
module yay0_lz_decompressor import ylz_pkg::*; #(
	parameter int unsigned WINDOW_SIZE = 4096,
	parameter int unsigned OUT_LANES   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_bytes,
	output logic [3:0]       byte_count,
	output logic             last_of_run,
	output logic [1:0]       next_need,
	output logic             done_res,
	output logic             error
);
	ylz_cmd_t    cmd;
	ylz_sts_t    sts;
	logic        cfg_we;
	logic [31:0] cfg_size;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_SIZE);
	assign prdata = (paddr[2] == REG_OUTPUT_SIZE) ? cfg_size : 32'd0;

	ylz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ylz_datapath #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.OUT_LANES   (OUT_LANES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (pwdata),
		.cfg_size    (cfg_size),
		.op          (op),
		.data        (data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_bytes   (out_bytes),
		.byte_count  (byte_count),
		.last_of_run (last_of_run),
		.next_need   (next_need),
		.done_res    (done_res),
		.error       (error)
	);
endmodule
`default_nettype wire
